FILE: src/cbez_pkg.sv
// cbez_pkg: constants shared by the cubic Bezier point evaluator.
// Widths of the fixed ports, default parameter values, register indexes.
// No dependencies.
package cbez_pkg;

	localparam int COORD_BITS   = 16;
	localparam int FRAC_BITS    = 15;
	localparam int PARAM_T_BITS = 16;
	localparam int NUM_CP       = 4;
	localparam int NUM_AXES     = 3;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] IDX_CP0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] IDX_CP1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] IDX_CP2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] IDX_CP3 = 3'd3;

endpackage

FILE: src/cubic_bezier_point_eval_core.sv
// cubic_bezier_point_eval_core: 3-D cubic Bezier evaluation, Bernstein form.
// Six-stage pipeline: clamp, t products, weights, coordinate products, sum, round.
// Depends on cbez_pkg.
//
//   channel  | ports                                | handshake
//   ---------+--------------------------------------+------------------------------
//   input    | param_t                              | start & !busy at clk edge
//   result   | point_x, point_y, point_z            | done, one cycle per item
//   config   | cfg_index, cfg_data                  | cfg_we at clk edge
//
// done follows acceptance through the valid chain v_s1 to v_s6; one item per cycle, busy is never set.
// The rate is set by the multiplier pipeline: stage 2 and 3 hold the weight products,
// stage 4 the twelve coordinate-by-weight products.
// arst_n clears the valid chain and the control points to zero.
// The receiver cannot stall, so results leave the output register on schedule.
module cubic_bezier_point_eval_core #(
	parameter int COORD_BITS = cbez_pkg::COORD_BITS,
	parameter int FRAC_BITS  = cbez_pkg::FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cbez_pkg::PARAM_T_BITS-1:0]   param_t,
	output logic                                done,
	output logic signed [COORD_BITS-1:0]        point_x,
	output logic signed [COORD_BITS-1:0]        point_y,
	output logic signed [COORD_BITS-1:0]        point_z,
	input  logic                                cfg_we,
	input  logic [cbez_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [3*COORD_BITS-1:0]             cfg_data
);

	localparam int C    = COORD_BITS;
	localparam int TW   = FRAC_BITS + 1;
	localparam int PW   = 2 * TW;
	localparam int CMPW = (TW > cbez_pkg::PARAM_T_BITS) ? TW : cbez_pkg::PARAM_T_BITS;
	localparam int PRW  = C + TW + 1;
	localparam int AW   = PRW + 2;
	localparam int SW   = TW + 2;
	localparam int NA   = cbez_pkg::NUM_AXES;
	localparam int NP   = cbez_pkg::NUM_CP;

	localparam logic [CMPW-1:0] ONE_CMP = CMPW'(1) << FRAC_BITS;
	localparam logic [TW-1:0]   ONE_TW  = TW'(1) << FRAC_BITS;
	localparam logic [PW-1:0]   HALF_P  = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] HALF_A = AW'(1) << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] CMAX   = (AW'(1) << (C - 1)) - AW'(1);
	localparam logic signed [AW-1:0] CMIN   = -CMAX - AW'(1);
	localparam logic [SW-1:0]   ONE_SW  = SW'(1) << FRAC_BITS;
	localparam logic [SW-1:0]   WTOL    = SW'(8);

	function automatic logic [TW-1:0] qmul(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [PW-1:0] p;
		p = PW'(a) * PW'(b) + HALF_P;
		return TW'(p >> FRAC_BITS);
	endfunction

	logic [3*C-1:0] cp_q [NP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NP; k++) begin
				cp_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				cbez_pkg::IDX_CP0: cp_q[0] <= cfg_data;
				cbez_pkg::IDX_CP1: cp_q[1] <= cfg_data;
				cbez_pkg::IDX_CP2: cp_q[2] <= cfg_data;
				cbez_pkg::IDX_CP3: cp_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 1: clamp, u = 1 - t
	logic [CMPW-1:0] t_ext;
	logic [CMPW-1:0] t_clamp;
	logic [TW-1:0]   t_s1, u_s1;

	assign t_ext   = CMPW'(param_t);
	assign t_clamp = (t_ext > ONE_CMP) ? ONE_CMP : t_ext;

	always_ff @(posedge clk) begin
		t_s1 <= t_clamp[TW-1:0];
		u_s1 <= ONE_TW - t_clamp[TW-1:0];
	end

	// stage 2: second-order products, 3*ut
	logic [TW-1:0] ut_c;
	logic [TW-1:0] t_s2, u_s2, uu_s2, tt_s2, ut3_s2;

	assign ut_c = qmul(u_s1, t_s1);

	always_ff @(posedge clk) begin
		t_s2   <= t_s1;
		u_s2   <= u_s1;
		uu_s2  <= qmul(u_s1, u_s1);
		tt_s2  <= qmul(t_s1, t_s1);
		ut3_s2 <= ut_c + {ut_c[TW-2:0], 1'b0};
	end

	// stage 3: Bernstein weights
	logic [TW-1:0] w_s3 [NP];

	always_ff @(posedge clk) begin
		w_s3[0] <= qmul(uu_s2, u_s2);
		w_s3[1] <= qmul(ut3_s2, u_s2);
		w_s3[2] <= qmul(ut3_s2, t_s2);
		w_s3[3] <= qmul(tt_s2, t_s2);
	end

	// stage 4: coordinate times weight
	logic signed [C-1:0]   crd [NA][NP];
	logic signed [TW:0]    wsg [NP];
	logic signed [PRW-1:0] prod_s4 [NA][NP];

	always_comb begin
		for (int k = 0; k < NP; k++) begin
			wsg[k] = $signed({1'b0, w_s3[k]});
			for (int a = 0; a < NA; a++) begin
				crd[a][k] = $signed(cp_q[k][a*C +: C]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NA; a++) begin
			for (int k = 0; k < NP; k++) begin
				prod_s4[a][k] <= crd[a][k] * wsg[k];
			end
		end
	end

	// stage 5: accumulate plus rounding half
	logic signed [AW-1:0] acc_s5 [NA];

	always_ff @(posedge clk) begin
		for (int a = 0; a < NA; a++) begin
			acc_s5[a] <= {{2{prod_s4[a][0][PRW-1]}}, prod_s4[a][0]}
				+ {{2{prod_s4[a][1][PRW-1]}}, prod_s4[a][1]}
				+ {{2{prod_s4[a][2][PRW-1]}}, prod_s4[a][2]}
				+ {{2{prod_s4[a][3][PRW-1]}}, prod_s4[a][3]}
				+ HALF_A;
		end
	end

	// stage 6: floor shift, saturate
	logic signed [AW-1:0] rnd [NA];
	logic signed [C-1:0]  pt_s6 [NA];

	always_comb begin
		for (int a = 0; a < NA; a++) begin
			rnd[a] = acc_s5[a] >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < NA; a++) begin
			if (rnd[a] > CMAX) begin
				pt_s6[a] <= CMAX[C-1:0];
			end else if (rnd[a] < CMIN) begin
				pt_s6[a] <= CMIN[C-1:0];
			end else begin
				pt_s6[a] <= rnd[a][C-1:0];
			end
		end
	end

	assign done    = v_s6;
	assign point_x = pt_s6[0];
	assign point_y = pt_s6[1];
	assign point_z = pt_s6[2];

	// weights form a partition of one, up to rounding
	logic [SW-1:0] wsum;
	assign wsum = SW'(w_s3[0]) + SW'(w_s3[1]) + SW'(w_s3[2]) + SW'(w_s3[3]);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result without an item accepted six cycles earlier");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted item produced no result");

	a_wsum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (wsum + WTOL >= ONE_SW) && (wsum <= ONE_SW + WTOL))
		else $error("Bernstein weights do not sum to one");

endmodule
